// File: rtl/kfct_pkg.sv
// kfct_pkg: shared types, codes and command/status bundles of the keyframe interpolator
`default_nettype none
package kfct_pkg;

   typedef struct packed {
      logic               action;
      logic [3:0]         point_index;
      logic [15:0]        key_position;
      logic signed [15:0] alpha_mult_in;
      logic signed [15:0] red_mult_in;
      logic signed [15:0] green_mult_in;
      logic signed [15:0] blue_mult_in;
      logic signed [15:0] alpha_off_in;
      logic signed [15:0] red_off_in;
      logic signed [15:0] green_off_in;
      logic signed [15:0] blue_off_in;
      logic [23:0]        distance;
   } req_type;

   typedef struct packed {
      logic signed [15:0] alpha_mult_out;
      logic signed [15:0] red_mult_out;
      logic signed [15:0] green_mult_out;
      logic signed [15:0] blue_mult_out;
      logic signed [15:0] alpha_off_out;
      logic signed [15:0] red_off_out;
      logic signed [15:0] green_off_out;
      logic signed [15:0] blue_off_out;
      logic               kept_previous;
   } rsp_type;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam logic REG_MAX_DISTANCE = 1'b0;
   localparam logic REG_POINT_COUNT  = 1'b1;

   localparam logic [1:0] RD_ZERO = 2'd0;
   localparam logic [1:0] RD_LAST = 2'd1;
   localparam logic [1:0] RD_IDX  = 2'd2;
   localparam logic [1:0] RD_PREV = 2'd3;

   localparam logic DIV_PATH   = 1'b0;
   localparam logic DIV_WEIGHT = 1'b1;

   localparam logic [16:0] U_ONE    = 17'h10000;
   localparam logic [15:0] MULT_ONE = 16'h1000;

   typedef struct packed {
      logic       load_wr;
      logic       capture;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       take;
      logic       t_save;
      logic       i_set1;
      logic       i_inc;
      logic       kprev_save;
      logic       k2_save;
      logic       div_init;
      logic       div_src;
      logic       div_step;
      logic       u_full_set;
      logic       u_save;
      logic       pa_save;
      logic       pb_save;
      logic       ch_clr;
      logic       mul;
      logic       acc;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic dist_zero;
      logic dist_ge_max;
      logic i_ge_n;
      logic i_next_ge_n;
      logic key_ge_t;
      logic div_done;
      logic u_full;
      logic ch_last;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/kfct_ctrl.sv
// kfct_ctrl: sequencer for load and evaluate beats
`default_nettype none
module kfct_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 action,
   input  kfct_pkg::status_type st,
   output kfct_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_valid,
   output logic                kept
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_DIV1  = 4'd2;
   localparam logic [3:0] S_SINIT = 4'd3;
   localparam logic [3:0] S_SK0   = 4'd4;
   localparam logic [3:0] S_SRD   = 4'd5;
   localparam logic [3:0] S_SCMP  = 4'd6;
   localparam logic [3:0] S_UPREP = 4'd7;
   localparam logic [3:0] S_DIV2  = 4'd8;
   localparam logic [3:0] S_UDONE = 4'd9;
   localparam logic [3:0] S_RB    = 4'd10;
   localparam logic [3:0] S_RC    = 4'd11;
   localparam logic [3:0] S_MUL   = 4'd12;
   localparam logic [3:0] S_ACC   = 4'd13;
   localparam logic [3:0] S_TAKE  = 4'd14;
   localparam logic [3:0] S_RESP  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       kept_ff, kept_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      kept_in  = kept_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (action == kfct_pkg::ACT_EVAL) begin
                  cmd.capture = 1'b1;
                  state_in    = S_CHECK;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (st.n_zero) begin
               kept_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               kept_in = 1'b0;
               if (st.dist_zero) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = kfct_pkg::RD_ZERO;
                  state_in   = S_TAKE;
               end else if (st.dist_ge_max) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = kfct_pkg::RD_LAST;
                  state_in   = S_TAKE;
               end else begin
                  cmd.div_init = 1'b1;
                  cmd.div_src  = kfct_pkg::DIV_PATH;
                  state_in     = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            if (st.div_done) state_in = S_SINIT;
         end
         S_SINIT: begin
            cmd.t_save = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = kfct_pkg::RD_ZERO;
            cmd.i_set1 = 1'b1;
            state_in   = S_SK0;
         end
         S_SK0: begin
            cmd.kprev_save = 1'b1;
            cmd.rd_en      = 1'b1;
            if (st.i_ge_n) begin
               cmd.rd_sel = kfct_pkg::RD_LAST;
               state_in   = S_TAKE;
            end else begin
               cmd.rd_sel = kfct_pkg::RD_IDX;
               state_in   = S_SCMP;
            end
         end
         S_SRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = kfct_pkg::RD_IDX;
            state_in   = S_SCMP;
         end
         S_SCMP: begin
            if (st.key_ge_t) begin
               cmd.k2_save = 1'b1;
               state_in    = S_UPREP;
            end else begin
               cmd.kprev_save = 1'b1;
               cmd.i_inc      = 1'b1;
               if (st.i_next_ge_n) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = kfct_pkg::RD_LAST;
                  state_in   = S_TAKE;
               end else begin
                  state_in = S_SRD;
               end
            end
         end
         S_UPREP: begin
            if (st.u_full) begin
               cmd.u_full_set = 1'b1;
               cmd.rd_en      = 1'b1;
               cmd.rd_sel     = kfct_pkg::RD_PREV;
               state_in       = S_RB;
            end else begin
               cmd.div_init = 1'b1;
               cmd.div_src  = kfct_pkg::DIV_WEIGHT;
               state_in     = S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            if (st.div_done) state_in = S_UDONE;
         end
         S_UDONE: begin
            cmd.u_save = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = kfct_pkg::RD_PREV;
            state_in   = S_RB;
         end
         S_RB: begin
            cmd.pa_save = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = kfct_pkg::RD_IDX;
            state_in    = S_RC;
         end
         S_RC: begin
            cmd.pb_save = 1'b1;
            cmd.ch_clr  = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = st.ch_last ? S_RESP : S_MUL;
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kept_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kept_ff  <= kept_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign kept      = kept_ff;

endmodule
`default_nettype wire

// File: rtl/kfct_dp.sv
// kfct_dp: keyframe memories, shared divider, search registers and channel lerp
`default_nettype none
module kfct_dp #(
   parameter int MAX_POINTS = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  kfct_pkg::req_type     req_data,
   input  wire  [23:0]           max_distance,
   input  wire  [4:0]            point_count,
   input  kfct_pkg::cmd_type     cmd,
   output kfct_pkg::status_type  st,
   output logic [63:0]           held_mult,
   output logic [63:0]           held_off
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [15:0] key_mem  [MAX_POINTS];
   logic [63:0] mult_mem [MAX_POINTS];
   logic [63:0] off_mem  [MAX_POINTS];

   logic [15:0] key_rd_ff;
   logic [63:0] mult_rd_ff, off_rd_ff;

   logic [CW-1:0] n_ff, i_ff;
   logic [23:0]   dist_ff;
   logic [15:0]   t_ff, kprev_ff, k2_ff;
   logic [23:0]   rem_ff, den_ff;
   logic [15:0]   q_ff;
   logic [3:0]    dcnt_ff;
   logic [16:0]   u_ff;
   logic [63:0]   pa_m_ff, pa_o_ff, pb_m_ff, pb_o_ff;
   logic [2:0]    ch_ff, chd_ff;
   logic signed [34:0] prod_ff;
   logic signed [15:0] a_ff;
   logic [63:0]   held_m_ff, held_m_in, held_o_ff, held_o_in;

   logic [AW-1:0] wr_addr, rd_addr;
   logic          slot_ok;
   logic [31:0]   count32;
   logic [CW-1:0] n_in;

   function automatic logic signed [15:0] lane(input logic [63:0] v, input logic [1:0] c);
      return v[{c, 4'd0} +: 16];
   endfunction

   assign slot_ok = (32'(req_data.point_index) < MAX_POINTS);
   assign wr_addr = AW'(req_data.point_index);
   assign count32 = 32'(point_count);
   assign n_in    = (count32 > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count32);

   always_comb begin
      case (cmd.rd_sel)
         kfct_pkg::RD_ZERO: rd_addr = '0;
         kfct_pkg::RD_LAST: rd_addr = AW'(n_ff - 1'b1);
         kfct_pkg::RD_IDX:  rd_addr = AW'(i_ff);
         kfct_pkg::RD_PREV: rd_addr = AW'(i_ff - 1'b1);
         default:           rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && slot_ok) begin
         key_mem[wr_addr]  <= req_data.key_position;
         mult_mem[wr_addr] <= {req_data.blue_mult_in, req_data.green_mult_in,
                               req_data.red_mult_in, req_data.alpha_mult_in};
         off_mem[wr_addr]  <= {req_data.blue_off_in, req_data.green_off_in,
                               req_data.red_off_in, req_data.alpha_off_in};
      end
      if (cmd.rd_en) begin
         key_rd_ff  <= key_mem[rd_addr];
         mult_rd_ff <= mult_mem[rd_addr];
         off_rd_ff  <= off_mem[rd_addr];
      end
   end

   // search and capture registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dist_ff <= req_data.distance;
         n_ff    <= n_in;
      end
      if (cmd.t_save)     t_ff     <= q_ff;
      if (cmd.kprev_save) kprev_ff <= key_rd_ff;
      if (cmd.k2_save)    k2_ff    <= key_rd_ff;
      if (cmd.i_set1)     i_ff     <= CW'(1);
      else if (cmd.i_inc) i_ff     <= i_ff + 1'b1;
   end

   // restoring divider, one quotient bit per cycle
   logic [24:0] rem2, rem_sub;
   logic        rem_ge;
   logic [15:0] wnum;

   assign rem2    = {rem_ff, 1'b0};
   assign rem_ge  = (rem2 >= {1'b0, den_ff});
   assign rem_sub = rem2 - {1'b0, den_ff};
   assign wnum    = (t_ff > kprev_ff) ? (t_ff - kprev_ff) : 16'd0;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dcnt_ff <= '0;
         if (cmd.div_src == kfct_pkg::DIV_PATH) begin
            rem_ff <= dist_ff;
            den_ff <= max_distance;
         end else begin
            rem_ff <= 24'(wnum);
            den_ff <= 24'(k2_ff - kprev_ff);
         end
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         rem_ff  <= rem_ge ? rem_sub[23:0] : rem2[23:0];
         q_ff    <= {q_ff[14:0], rem_ge};
      end
      if (cmd.u_full_set)  u_ff <= kfct_pkg::U_ONE;
      else if (cmd.u_save) u_ff <= {1'b0, q_ff};
   end

   // channel lerp, one channel at a time through the multiplier, a multiply then an accumulate step
   logic signed [15:0] lane_a, lane_b, acc_v;
   logic signed [16:0] diff;
   logic signed [17:0] u_s;
   logic signed [34:0] rnd;

   assign lane_a = ch_ff[2] ? lane(pa_o_ff, ch_ff[1:0]) : lane(pa_m_ff, ch_ff[1:0]);
   assign lane_b = ch_ff[2] ? lane(pb_o_ff, ch_ff[1:0]) : lane(pb_m_ff, ch_ff[1:0]);
   assign diff   = {lane_b[15], lane_b} - {lane_a[15], lane_a};
   assign u_s    = signed'({1'b0, u_ff});
   assign rnd    = prod_ff + 35'sd32768;
   assign acc_v  = a_ff + 16'(rnd >>> 16);

   always_ff @(posedge clock) begin
      if (cmd.pa_save) begin
         pa_m_ff <= mult_rd_ff;
         pa_o_ff <= off_rd_ff;
      end
      if (cmd.pb_save) begin
         pb_m_ff <= mult_rd_ff;
         pb_o_ff <= off_rd_ff;
      end
      if (cmd.ch_clr) ch_ff <= '0;
      else if (cmd.mul) ch_ff <= ch_ff + 1'b1;
      if (cmd.mul) begin
         prod_ff <= u_s * diff;
         a_ff    <= lane_a;
         chd_ff  <= ch_ff;
      end
   end

   always_comb begin
      held_m_in = held_m_ff;
      held_o_in = held_o_ff;
      if (cmd.take) begin
         held_m_in = mult_rd_ff;
         held_o_in = off_rd_ff;
      end else if (cmd.acc) begin
         if (chd_ff[2]) held_o_in[{chd_ff[1:0], 4'd0} +: 16] = acc_v;
         else           held_m_in[{chd_ff[1:0], 4'd0} +: 16] = acc_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_m_ff <= {4{kfct_pkg::MULT_ONE}};
         held_o_ff <= '0;
      end else begin
         held_m_ff <= held_m_in;
         held_o_ff <= held_o_in;
      end
   end

   assign held_mult = held_m_ff;
   assign held_off  = held_o_ff;

   assign st.n_zero      = (n_ff == '0);
   assign st.dist_zero   = (dist_ff == '0);
   assign st.dist_ge_max = (dist_ff >= max_distance);
   assign st.i_ge_n      = (i_ff >= n_ff);
   assign st.i_next_ge_n = (({1'b0, i_ff} + 1'b1) >= {1'b0, n_ff});
   assign st.key_ge_t    = (key_rd_ff >= t_ff);
   assign st.div_done    = (dcnt_ff == 4'hf);
   assign st.u_full      = (k2_ff <= kprev_ff) || (t_ff >= k2_ff);
   assign st.ch_last     = (chd_ff == 3'd7);

endmodule
`default_nettype wire

// File: rtl/keyframe_color_transform_lerp.sv
// keyframe_color_transform_lerp: top level with control registers, sequencer and datapath
`default_nettype none
// Colour-transform keyframe interpolator. A load beat (action 0) writes one keyframe slot in
// the same cycle it is accepted and gives no result; busy stays low. An evaluate beat
// (action 1) turns the distance into a path fraction with a one-bit-per-cycle divider,
// walks the key memory one slot at a time, reading then comparing each, to find the
// bracketing pair, runs the divider again for the weight, then lerps the eight channels
// through one shared multiplier, a multiply then an accumulate step per channel. An empty
// table returns the held transform unchanged with kept_previous set; a distance of zero or
// at or above max_distance takes the first or last keyframe, and a search that finds no
// bracketing key takes the last one. The result beat is the last busy cycle and the next
// beat can be taken in the cycle after it.
// The result is shown on rsp_* for one cycle with rsp_valid and cannot be held off, so the
// receiver must take it then. Configuration may only be written while busy is low.
module keyframe_color_transform_lerp #(
   parameter int MAX_POINTS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  kfct_pkg::req_type   req_data,
   output logic                rsp_valid,
   output kfct_pkg::rsp_type   rsp_data,
   input  wire                 csr_we,
   input  wire                 csr_index,
   input  wire  [23:0]         csr_wdata
);

   // control registers
   logic [23:0] max_distance_ff;
   logic [4:0]  point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= 24'd35840;
         point_count_ff  <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            kfct_pkg::REG_MAX_DISTANCE: max_distance_ff <= csr_wdata;
            kfct_pkg::REG_POINT_COUNT:  point_count_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   kfct_pkg::cmd_type    cmd;
   kfct_pkg::status_type st;
   logic                 kept;
   logic [63:0]          held_mult, held_off;

   // sequencer
   kfct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .action    (req_data.action),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .kept      (kept)
   );

   // memories, divider, multiplier
   kfct_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .max_distance (max_distance_ff),
      .point_count  (point_count_ff),
      .cmd          (cmd),
      .st           (st),
      .held_mult    (held_mult),
      .held_off     (held_off)
   );

   // result beat straight from the held transform
   assign rsp_data.alpha_mult_out = held_mult[15:0];
   assign rsp_data.red_mult_out   = held_mult[31:16];
   assign rsp_data.green_mult_out = held_mult[47:32];
   assign rsp_data.blue_mult_out  = held_mult[63:48];
   assign rsp_data.alpha_off_out  = held_off[15:0];
   assign rsp_data.red_off_out    = held_off[31:16];
   assign rsp_data.green_off_out  = held_off[47:32];
   assign rsp_data.blue_off_out   = held_off[63:48];
   assign rsp_data.kept_previous  = kept;

`ifndef SYNTH
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat longer than one cycle");
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == kfct_pkg::ACT_EVAL) |=> busy)
      else $error("evaluate beat did not start work");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == kfct_pkg::ACT_LOAD) |=> !busy && !rsp_valid)
      else $error("load beat started work");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside evaluate");
`endif

endmodule
`default_nettype wire
